/* hw/rtl/spt_pkg.sv */
`timescale 1ns / 1ps

package spt_pkg;

  localparam int SPT_DEPTH = 64;

  localparam int OPW = 2;
  localparam int IDW = 32;
  localparam int LVW = 8;
  localparam int SCW = 16;
  localparam int IXW = 6;
  localparam int STW = 3;
  localparam int ECW = 7;

  localparam int IN_W  = 64;
  localparam int OUT_W = 72;

  localparam logic [OPW-1:0] OP_ADD    = 2'd0;
  localparam logic [OPW-1:0] OP_DELETE = 2'd1;
  localparam logic [OPW-1:0] OP_READ   = 2'd2;
  localparam logic [OPW-1:0] OP_LOOKUP = 2'd3;

  localparam logic [STW-1:0] ST_OK        = 3'd0;
  localparam logic [STW-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STW-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STW-1:0] ST_INVALID   = 3'd3;
  localparam logic [STW-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [IDW-1:0]        id;
    logic [LVW-1:0]        lvl;
    logic signed [SCW-1:0] scr;
  } spt_entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic           cmp;  // capture compare flags
    logic           ins;  // insert cmd.ent at the ordered position
    logic           del;  // close the gap at the selected cell
    logic           rd;   // select by index rather than by id
    logic [IXW-1:0] idx;
    spt_entry_t     ent;
  } spt_cmd_t;

endpackage

/* hw/rtl/sorted_priority_table_core.sv */
`timescale 1ns / 1ps

// Sorted priority table: entries (id, level, score) kept in descending level
// order, equal levels after the existing ones, in a row of cells.
// Input stream s_*: one command per transaction (add, delete by id, read by
// index, lookup by id). Output stream m_*: exactly one response per command,
// with status, the entry found, read or removed, and the entry count after.
// A command passes a compare state, in which all cells compare against it in
// parallel and register their flags, then an execute state, which shifts the
// row and registers the response. A new command is taken only as the previous
// one completes in its execute state, so commands do not overlap in the row.
// The selection has at most one bit set, so the selected entry and the match flag are
// OR-gathered along the row and balance into a tree of log2(TABLE_DEPTH) levels.
// Reset empties the table at once; no clearing pass is needed.
// When the receiver stalls, the response is held in the output register;
// the next command may still be accepted and compared, and it completes once
// the held response has been taken.

module sorted_priority_table_core import spt_pkg::*; #(
  parameter int TABLE_DEPTH = SPT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // opcode[1:0], user_id[33:2], level[41:34], score[57:42], entry_index[63:58]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status[2:0], out_id[34:3], out_level[42:35], out_score[58:43],
  // entry_count[65:59], zero padding [71:66]
  output logic [OUT_W-1:0] m_tdata
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC} state_t;

  state_t          state;
  logic [OPW-1:0]  op;
  spt_entry_t      cmd_ent;
  logic [IXW-1:0]  idx;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;

  spt_cmd_t        cmd;
  logic            out_free;
  logic            fire;
  logic            hit;
  spt_entry_t      found;

  logic [STW-1:0]  status_c;
  spt_entry_t      out_c;
  logic            ins_c;
  logic            del_c;
  logic            full;
  logic [CW+ECW-1:0] count_ext;

  spt_entry_t          ent_w   [TABLE_DEPTH];
  spt_entry_t          found_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ge_w;
  logic [TABLE_DEPTH-1:0] sel_w;
  logic [TABLE_DEPTH-1:0] seen_w;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = (state == S_EXEC) && out_free;
  assign s_tready = (state == S_IDLE) || fire;
  assign full     = count == CW'(TABLE_DEPTH);
  assign hit      = seen_w[TABLE_DEPTH-1];
  assign found    = found_w[TABLE_DEPTH-1];

  always_comb begin
    status_c   = ST_OK;
    out_c      = '0;
    ins_c      = 1'b0;
    del_c      = 1'b0;
    count_next = count;
    if (op == OP_READ) begin
      if (hit) begin
        out_c = found;
      end else begin
        status_c = ST_INVALID;
      end
    end else if (cmd_ent.id == '0) begin
      status_c = ST_INVALID;
    end else begin
      case (op)
        OP_ADD: begin
          if (hit) begin
            status_c = ST_PRESENT;
            out_c    = found;
          end else if (full) begin
            status_c = ST_FULL;
          end else begin
            ins_c      = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_DELETE: begin
          if (hit) begin
            out_c      = found;
            del_c      = 1'b1;
            count_next = count - 1'b1;
          end else begin
            status_c = ST_NOT_FOUND;
          end
        end
        default: begin
          if (hit) begin
            out_c = found;
          end else begin
            status_c = ST_NOT_FOUND;
          end
        end
      endcase
    end
  end

  assign count_ext = {{ECW{1'b0}}, count_next};

  assign cmd.cmp = (state == S_CMP);
  assign cmd.ins = fire && ins_c;
  assign cmd.del = fire && del_c;
  assign cmd.rd  = (op == OP_READ);
  assign cmd.idx = idx;
  assign cmd.ent = cmd_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (fire) begin
            count <= count_next;
            state <= s_tvalid ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command and response payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op          <= s_tdata[1:0];
      cmd_ent.id  <= s_tdata[33:2];
      cmd_ent.lvl <= s_tdata[41:34];
      cmd_ent.scr <= s_tdata[57:42];
      idx         <= s_tdata[63:58];
    end
    if (fire) begin
      m_tdata <= {{(OUT_W - 66){1'b0}}, count_ext[ECW-1:0], out_c.scr, out_c.lvl,
                  out_c.id, status_c};
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    spt_entry_t left_ent;
    logic       left_ge;
    spt_entry_t right_ent;
    logic       seen_in;
    spt_entry_t found_in;

    if (i == 0) begin : g_first
      assign left_ent = cmd_ent;
      assign left_ge  = 1'b1;
      assign seen_in  = 1'b0;
      assign found_in = '0;
    end else begin : g_rest
      assign left_ent = ent_w[i-1];
      assign left_ge  = ge_w[i-1];
      assign seen_in  = seen_w[i-1];
      assign found_in = found_w[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_ent = ent_w[i];
    end else begin : g_mid
      assign right_ent = ent_w[i+1];
    end

    spt_cell #(
      .DEPTH (TABLE_DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .count     (count),
      .left_ent  (left_ent),
      .left_ge   (left_ge),
      .right_ent (right_ent),
      .seen_in   (seen_in),
      .found_in  (found_in),
      .ent       (ent_w[i]),
      .ge        (ge_w[i]),
      .sel       (sel_w[i]),
      .seen_out  (seen_w[i]),
      .found_out (found_w[i])
    );
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(count))
    else $error("entry count moved without a completed command");

  a_accept_cmp: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_CMP))
    else $error("accepted transaction did not enter compare");

  a_single_sel: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(sel_w))
    else $error("more than one cell selected");
`endif

endmodule

/* hw/rtl/spt_cell.sv */
`timescale 1ns / 1ps

module spt_cell import spt_pkg::*; #(
  parameter int DEPTH = SPT_DEPTH,
  parameter int INDEX = 0,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  spt_cmd_t      cmd,
  input  logic [CW-1:0] count,
  input  spt_entry_t    left_ent,
  input  logic          left_ge,
  input  spt_entry_t    right_ent,
  input  logic          seen_in,
  input  spt_entry_t    found_in,
  output spt_entry_t    ent,
  output logic          ge,
  output logic          sel,
  output logic          seen_out,
  output spt_entry_t    found_out
);

  logic valid;
  logic idx_hit;

  assign valid    = count > CW'(INDEX);
  assign idx_hit  = 32'(cmd.idx) == 32'(INDEX);

  // OR the selection prefix and the selected entry down the row; at most one
  // cell is selected, so the gather balances into a tree
  assign seen_out  = seen_in | sel;
  assign found_out = found_in | (sel ? ent : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ge  <= 1'b0;
      sel <= 1'b0;
    end else if (cmd.cmp) begin
      ge  <= valid && (ent.lvl >= cmd.ent.lvl);
      sel <= valid && (cmd.rd ? idx_hit : (ent.id == cmd.ent.id));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      // left neighbour at or past the insert point: shift down
      if (!left_ge) begin
        ent <= left_ent;
      end else if (!ge) begin
        ent <= cmd.ent;
      end
    end else if (cmd.del) begin
      if (seen_out) begin
        ent <= right_ent;
      end
    end
  end

endmodule

/* verif/sorted_priority_table_core_test.sv */
`timescale 1ns / 1ps

module sorted_priority_table_core_test;
  import spt_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [OPW-1:0] op;
    spt_entry_t     ent;
    logic [IXW-1:0] idx;
  } command_t;

  typedef struct {
    logic [STW-1:0] status;
    spt_entry_t     ent;
    logic [ECW-1:0] count;
  } response_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // Shadow of the block: ordered rows and their count
  spt_entry_t rows [SPT_DEPTH];
  int         row_total = 0;
  response_t  pending_responses [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  int  hold_off_left = 0;
  bit  quiet = 1'b0;

  sorted_priority_table_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int find_row(logic [IDW-1:0] id);
    for (int k = row_total - 1; k >= 0; k--) begin
      if (rows[k].id == id) return k;
    end
    return -1;
  endfunction

  // Apply one command to the shadow rows and give the response it causes
  function automatic response_t table_response(command_t c);
    response_t r;
    int        pos;
    int        at;
    r.status = ST_OK;
    r.ent = '0;
    if (c.op == OP_READ) begin
      if (int'(c.idx) < row_total) r.ent = rows[c.idx];
      else r.status = ST_INVALID;
    end else if (c.ent.id == '0) begin
      r.status = ST_INVALID;
    end else begin
      pos = find_row(c.ent.id);
      case (c.op)
        OP_ADD: begin
          if (pos >= 0) begin
            r.status = ST_PRESENT;
            r.ent = rows[pos];
          end else if (row_total >= SPT_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            at = 0;
            while (at < row_total && rows[at].lvl >= c.ent.lvl) at++;
            for (int k = row_total; k > at; k--) rows[k] = rows[k-1];
            rows[at] = c.ent;
            row_total++;
          end
        end
        OP_DELETE: begin
          if (pos < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.ent = rows[pos];
            for (int k = pos; k < row_total - 1; k++) rows[k] = rows[k+1];
            row_total--;
          end
        end
        default: begin
          if (pos < 0) r.status = ST_NOT_FOUND;
          else r.ent = rows[pos];
        end
      endcase
    end
    r.count = row_total[ECW-1:0];
    return r;
  endfunction

  // Offer one command, hold it until taken, then record its response
  task automatic send_command(logic [OPW-1:0] op, logic [IDW-1:0] id, logic [LVW-1:0] lvl,
                              logic [SCW-1:0] scr, logic [IXW-1:0] idx);
    command_t c;
    c.op = op;
    c.ent.id = id;
    c.ent.lvl = lvl;
    c.ent.scr = scr;
    c.idx = idx;
    while (!quiet && $urandom_range(0, 99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c.idx, c.ent.scr, c.ent.lvl, c.ent.id, c.op};
    do @(posedge clk); while (!s_tready);
    pending_responses.insert(pending_responses.size(), table_response(c));
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IDW-1:0] pick_id(int present_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 5 + present_pct && row_total > 0) return rows[$urandom_range(0, row_total - 1)].id;
    return $urandom;
  endfunction

  task automatic test_directed();
    send_command(OP_READ, '0, '0, '0, 6'd0);
    send_command(OP_READ, '0, '0, '0, 6'd63);
    send_command(OP_LOOKUP, 32'd5, '0, '0, '0);
    send_command(OP_DELETE, 32'd5, '0, '0, '0);
    send_command(OP_ADD, '0, 8'd9, 16'sd3, '0);
    send_command(OP_DELETE, '0, '0, '0, '0);
    send_command(OP_LOOKUP, '0, '0, '0, '0);
    send_command(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 16'h7FFF, 6'h3F);
    send_command(OP_ADD, 32'd1, 8'h00, 16'h8000, '0);
    // equal level goes after the ones already there
    send_command(OP_ADD, 32'd2, 8'hFF, 16'hFFFF, '0);
    send_command(OP_ADD, 32'd3, 8'h80, 16'h0001, '0);
    send_command(OP_ADD, 32'd4, 8'h00, 16'h1234, '0);
    send_command(OP_ADD, 32'd1, 8'h55, 16'h4321, '0);
    send_command(OP_READ, '0, '0, '0, 6'd0);
    send_command(OP_READ, '0, '0, '0, 6'd1);
    send_command(OP_READ, '0, '0, '0, 6'd4);
    send_command(OP_READ, '0, '0, '0, 6'd5);
    send_command(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
    send_command(OP_LOOKUP, 32'h8000_0000, '0, '0, '0);
    send_command(OP_DELETE, 32'd2, '0, '0, '0);
    send_command(OP_DELETE, 32'd2, '0, '0, '0);
    send_command(OP_READ, '0, '0, '0, 6'd1);
    send_command(OP_DELETE, 32'hFFFF_FFFF, '0, '0, '0);
    send_command(OP_READ, '0, '0, '0, 6'd3);
    wait_for_drain();
  endtask

  // Fill to capacity behind a stalled receiver, probe the full table, then empty it
  task automatic test_fill_and_empty();
    int gone;
    hold_off_left = HOLD_OFF_CYCLES;
    while (row_total < SPT_DEPTH) begin
      send_command(OP_ADD, IDW'($urandom | 32'h1), LVW'($urandom), SCW'($urandom),
                   IXW'($urandom));
    end
    send_command(OP_ADD, IDW'($urandom | 32'h1), LVW'($urandom), SCW'($urandom), '0);
    send_command(OP_ADD, rows[SPT_DEPTH-1].id, 8'd0, 16'd0, '0);
    send_command(OP_ADD, '0, 8'd1, 16'd1, '0);
    send_command(OP_READ, '0, '0, '0, 6'd63);
    send_command(OP_LOOKUP, rows[0].id, '0, '0, '0);
    gone = 0;
    while (row_total > 0) begin
      if (gone % 3 == 0) send_command(OP_DELETE, rows[row_total-1].id, '0, '0, '0);
      else send_command(OP_DELETE, rows[$urandom_range(0, row_total - 1)].id, '0, '0, '0);
      gone++;
    end
    send_command(OP_READ, '0, '0, '0, 6'd0);
    wait_for_drain();
  endtask

  task automatic test_random_mix(int count);
    int              add_bias;
    int              r;
    logic [LVW-1:0]  lvl;
    logic [IXW-1:0]  idx;
    add_bias = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: add_bias = 15;
          1: add_bias = 50;
          default: add_bias = 92;
        endcase
      end
      quiet = (n >= 300 && n < 450);
      r = $urandom_range(0, 99);
      lvl = ($urandom_range(0, 1) != 0) ? LVW'($urandom_range(0, 7)) : LVW'($urandom);
      if (r < 5) begin
        send_command(OPW'($urandom), $urandom, LVW'($urandom), SCW'($urandom),
                     IXW'($urandom));
      end else if (r < 65) begin
        if ($urandom_range(0, 99) < add_bias)
          send_command(OP_ADD, pick_id(20), lvl, SCW'($urandom), IXW'($urandom));
        else
          send_command(OP_DELETE, pick_id(75), LVW'($urandom), SCW'($urandom),
                       IXW'($urandom));
      end else if (r < 82) begin
        send_command(OP_LOOKUP, pick_id(75), LVW'($urandom), SCW'($urandom),
                     IXW'($urandom));
      end else begin
        if ($urandom_range(0, 99) < 70 && row_total > 0)
          idx = IXW'($urandom_range(0, row_total - 1));
        else idx = IXW'($urandom);
        send_command(OP_READ, $urandom, LVW'($urandom), SCW'($urandom), idx);
      end
    end
    quiet = 1'b0;
    wait_for_drain();
  endtask

  // Receiver: random back-pressure (none while quiet), or a counted hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      m_tready <= 1'b0;
      hold_off_left--;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    response_t got;
    response_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[2:0];
      got.ent.id = m_tdata[34:3];
      got.ent.lvl = m_tdata[42:35];
      got.ent.scr = m_tdata[58:43];
      got.count = m_tdata[65:59];
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("response with nothing outstanding: %h", m_tdata));
      end else begin
        want = pending_responses.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.ent.id !== want.ent.id)
          report_mismatch($sformatf("out_id %h, want %h", got.ent.id, want.ent.id));
        if (got.ent.lvl !== want.ent.lvl)
          report_mismatch($sformatf("out_level %h, want %h", got.ent.lvl, want.ent.lvl));
        if (got.ent.scr !== want.ent.scr)
          report_mismatch($sformatf("out_score %h, want %h", got.ent.scr, want.ent.scr));
        if (got.count !== want.count)
          report_mismatch($sformatf("entry_count %0d, want %0d", got.count, want.count));
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_empty();
    test_random_mix(1050);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
